FILE: rtl/core/drh_pkg.sv
// Package: types and constants for the double rolling substring hash block.
`default_nettype none
package drh_pkg;

    localparam int WRAP_W = 64;
    localparam int MOD_W  = 30;

    localparam logic [MOD_W-1:0]  HASH_BASE    = 30'd1000000007;
    localparam logic [MOD_W-1:0]  HASH_MODULUS = 30'd1000000021;

    // floor(2^60 / M), for the quotient estimate of a 60-bit product.
    localparam logic [31:0] MOD_RECIP = 32'((64'd1 << 60) / 64'(HASH_MODULUS));

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  char_code;
        logic [10:0] range_begin;
        logic [10:0] range_end;
    } cmd_t;

    typedef struct packed {
        logic [WRAP_W-1:0] hash_wrap;
        logic [MOD_W-1:0]  hash_mod;
        logic [1:0]        status;
    } rsp_t;

    // Operands for one pass of the shared multiply unit.
    typedef struct packed {
        logic [WRAP_W-1:0] a_wrap;
        logic [WRAP_W-1:0] b_wrap;
        logic [MOD_W-1:0]  a_mod;
        logic [MOD_W-1:0]  b_mod;
    } mul_req_t;

    // Steps of one multiply pass.
    typedef enum logic [2:0] {
        MS_LL,
        MS_LH,
        MS_HL,
        MS_MOD,
        MS_QUO,
        MS_REM,
        MS_RED
    } mul_step_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ZERO,
        S_A_RD,
        S_A_GO1,
        S_A_WT1,
        S_A_GO2,
        S_A_WT2,
        S_A_WR,
        S_Q_RD1,
        S_Q_RD2,
        S_Q_GO,
        S_Q_WT,
        S_Q_OUT
    } state_t;

endpackage
`default_nettype wire

FILE: rtl/core/drh_mulunit.sv
// Shared multiply unit: 64-bit wrapping product and modular product on one 32x32 multiplier.
`default_nettype none
module drh_mulunit (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     go,
    input  wire drh_pkg::mul_req_t        req,
    output logic                          done,
    output logic [drh_pkg::WRAP_W-1:0]    prod_wrap,
    output logic [drh_pkg::MOD_W-1:0]     prod_mod
);
    import drh_pkg::*;

    localparam logic [31:0] MOD32  = {2'b0, HASH_MODULUS};
    localparam logic [31:0] MOD2X  = {1'b0, HASH_MODULUS, 1'b0};

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    mul_step_t         step_reg, step_next;
    mul_req_t          op_reg, op_next;
    logic [WRAP_W-1:0] accw_reg, accw_next;
    logic [MOD_W-1:0]  accm_reg, accm_next;
    logic [59:0]       pm_reg, pm_next;    // a_mod*b_mod, later the remainder estimate
    logic [31:0]       q_reg, q_next;      // quotient estimate, at most two short

    logic [31:0] mul_a, mul_b;
    logic [63:0] pp;
    logic [31:0] red_r;

    // Step sequence.
    always_comb
    begin
        step_next = step_reg;
        if (go)
            step_next = MS_LL;
        else if (busy_reg)
        begin
            case (step_reg)
                MS_LL:   step_next = MS_LH;
                MS_LH:   step_next = MS_HL;
                MS_HL:   step_next = MS_MOD;
                MS_MOD:  step_next = MS_QUO;
                MS_QUO:  step_next = MS_REM;
                MS_REM:  step_next = MS_RED;
                default: step_next = MS_LL;
            endcase
        end
    end

    // Multiplier operands per step; low 64 bits of the wrap product need three.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            MS_LL:
            begin
                mul_a = op_reg.a_wrap[31:0];
                mul_b = op_reg.b_wrap[31:0];
            end
            MS_LH:
            begin
                mul_a = op_reg.a_wrap[31:0];
                mul_b = op_reg.b_wrap[63:32];
            end
            MS_HL:
            begin
                mul_a = op_reg.a_wrap[63:32];
                mul_b = op_reg.b_wrap[31:0];
            end
            MS_MOD:
            begin
                mul_a = {2'b0, op_reg.a_mod};
                mul_b = {2'b0, op_reg.b_mod};
            end
            MS_QUO:
            begin
                mul_a = {1'b0, pm_reg[59:29]};
                mul_b = MOD_RECIP;
            end
            MS_REM:
            begin
                mul_a = q_reg;
                mul_b = MOD32;
            end
            default: ;
        endcase
        pp = mul_a * mul_b;
    end

    // Remainder estimate is below 3M; at most two subtracts.
    always_comb
    begin
        if (pm_reg[31:0] >= MOD2X)
            red_r = pm_reg[31:0] - MOD2X;
        else if (pm_reg[31:0] >= MOD32)
            red_r = pm_reg[31:0] - MOD32;
        else
            red_r = pm_reg[31:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        accw_next = accw_reg;
        accm_next = accm_reg;
        pm_next   = pm_reg;
        q_next    = q_reg;
        if (go)
        begin
            busy_next = 1'b1;
            op_next   = req;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                MS_LL:        accw_next = pp;
                MS_LH, MS_HL: accw_next = accw_reg + {pp[31:0], 32'd0};
                MS_MOD:       pm_next   = pp[59:0];
                MS_QUO:       q_next    = pp[62:31];
                MS_REM:       pm_next   = {28'd0, pm_reg[31:0] - pp[31:0]};
                MS_RED:
                begin
                    accm_next = red_r[MOD_W-1:0];
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= MS_LL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        accw_reg <= accw_next;
        accm_reg <= accm_next;
        pm_reg   <= pm_next;
        q_reg    <= q_next;
    end

    assign done      = done_reg;
    assign prod_wrap = accw_reg;
    assign prod_mod  = accm_reg;

endmodule
`default_nettype wire

FILE: rtl/core/double_rolling_substring_hash.sv
// Top level: double polynomial rolling hash over a byte string with substring queries.
//
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+------------------------------
//  command   | in        | start && !busy              | cmd  (operation, char, range)
//  response  | out       | rsp_valid, one-cycle strobe | rsp  (hash_wrap, hash_mod, status)
//
// A transaction runs to completion before the next command is accepted. The shared
// multiply unit does most of the work: each pass is seven steps on one 32x32
// multiplier (three wrap partial products, the modular product, a reciprocal
// quotient estimate, the remainder, a final correction); append takes two passes
// (prefix and power), query one, plus memory reads; clear and rejected commands none.
// Reset clears the length and control; table contents are left as they are.
// Entry zero of both tables is never written and reads as its fixed value.
// The receiver cannot stall: rsp_valid is high one cycle, busy is low then.
`default_nettype none
module double_rolling_substring_hash #(
    parameter int MAX_LEN = 1024
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire drh_pkg::cmd_t cmd,
    output logic               rsp_valid,
    output drh_pkg::rsp_t      rsp
);
    import drh_pkg::*;

    localparam int AW = $clog2(MAX_LEN + 1);
    localparam int CW = (AW > 11) ? AW : 11;
    localparam int EW = WRAP_W + MOD_W;
    localparam logic [AW-1:0] MAX_A = AW'(MAX_LEN);

    state_t state_reg, state_next;

    cmd_t              cmd_reg;
    logic [AW-1:0]     len_reg, len_next;
    logic [1:0]        zstat_reg, zstat_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;
    logic [WRAP_W-1:0] hold_w_reg;    // new prefix (append) or prefix[hi] (query)
    logic [MOD_W-1:0]  hold_m_reg;

    // Tables: {wrap, mod} per entry.
    logic [EW-1:0] pre_mem [0:MAX_LEN];
    logic [EW-1:0] pow_mem [0:MAX_LEN];
    logic [EW-1:0] pre_rd_reg, pow_rd_reg;
    logic          pre_zero_reg, pow_zero_reg;

    logic          pre_re, pow_re, mem_we;
    logic [AW-1:0] pre_raddr, pow_raddr, waddr;
    logic          mul_go, mul_done;
    mul_req_t      mul_req;
    logic [WRAP_W-1:0] prod_w;
    logic [MOD_W-1:0]  prod_m;

    logic [WRAP_W-1:0] pre_w, pow_w;
    logic [MOD_W-1:0]  pre_m, pow_m;

    logic              accept;
    op_t               op_in;
    logic [CW-1:0]     lo_c, hi_c, len_c;
    logic              range_ok;
    logic [AW-1:0]     lo_a, hi_a, span_a;
    logic [MOD_W:0]    app_m, sub_m;
    logic [MOD_W-1:0]  app_red, sub_red;

    assign accept = start && !busy;
    assign op_in  = op_t'(cmd.operation);
    assign lo_c   = CW'(cmd.range_begin);
    assign hi_c   = CW'(cmd.range_end);
    assign len_c  = CW'(len_reg);
    assign range_ok = (lo_c <= hi_c) && (hi_c <= len_c);

    // Indices of the latched command; valid only after the range check passed.
    assign lo_a   = AW'(CW'(cmd_reg.range_begin));
    assign hi_a   = AW'(CW'(cmd_reg.range_end));
    assign span_a = hi_a - lo_a;

    // Entry zero reads as fixed values: prefix zero, power one.
    assign pre_w = pre_zero_reg ? '0 : pre_rd_reg[EW-1:MOD_W];
    assign pre_m = pre_zero_reg ? '0 : pre_rd_reg[MOD_W-1:0];
    assign pow_w = pow_zero_reg ? WRAP_W'(1) : pow_rd_reg[EW-1:MOD_W];
    assign pow_m = pow_zero_reg ? MOD_W'(1) : pow_rd_reg[MOD_W-1:0];

    // (prefix*B mod M) + byte, one conditional subtract.
    assign app_m   = {1'b0, prod_m} + (MOD_W+1)'(cmd_reg.char_code);
    assign app_red = (app_m >= {1'b0, HASH_MODULUS}) ?
                     MOD_W'(app_m - {1'b0, HASH_MODULUS}) : app_m[MOD_W-1:0];
    // prefix[hi] - prefix[lo]*pow[span] mod M.
    assign sub_m   = {1'b0, hold_m_reg} - {1'b0, prod_m};
    assign sub_red = sub_m[MOD_W] ? MOD_W'(sub_m + {1'b0, HASH_MODULUS}) : sub_m[MOD_W-1:0];

    drh_mulunit u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (mul_go),
        .req       (mul_req),
        .done      (mul_done),
        .prod_wrap (prod_w),
        .prod_mod  (prod_m)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    case (op_in)
                        OP_APPEND: state_next = (len_reg == MAX_A) ? S_ZERO : S_A_RD;
                        OP_QUERY:  state_next = range_ok ? S_Q_RD1 : S_ZERO;
                        default:   state_next = S_ZERO;
                    endcase
                end
            S_ZERO:  state_next = S_IDLE;
            S_A_RD:  state_next = S_A_GO1;
            S_A_GO1: state_next = S_A_WT1;
            S_A_WT1: if (mul_done) state_next = S_A_GO2;
            S_A_GO2: state_next = S_A_WT2;
            S_A_WT2: if (mul_done) state_next = S_A_WR;
            S_A_WR:  state_next = S_IDLE;
            S_Q_RD1: state_next = S_Q_RD2;
            S_Q_RD2: state_next = S_Q_GO;
            S_Q_GO:  state_next = S_Q_WT;
            S_Q_WT:  if (mul_done) state_next = S_Q_OUT;
            S_Q_OUT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        busy      = (state_reg != S_IDLE);
        pre_re    = 1'b0;
        pow_re    = 1'b0;
        pre_raddr = len_reg;
        pow_raddr = len_reg;
        mem_we    = 1'b0;
        waddr     = len_reg + AW'(1);
        mul_go    = 1'b0;
        mul_req   = '{a_wrap: pre_w, b_wrap: WRAP_W'(HASH_BASE),
                      a_mod: pre_m, b_mod: HASH_BASE};
        case (state_reg)
            S_A_RD:
            begin
                pre_re = 1'b1;
                pow_re = 1'b1;
            end
            S_A_GO1: mul_go = 1'b1;
            S_A_GO2:
            begin
                mul_go  = 1'b1;
                mul_req = '{a_wrap: pow_w, b_wrap: WRAP_W'(HASH_BASE),
                            a_mod: pow_m, b_mod: HASH_BASE};
            end
            S_A_WR:  mem_we = 1'b1;
            S_Q_RD1:
            begin
                pre_re    = 1'b1;
                pre_raddr = hi_a;
                pow_re    = 1'b1;
                pow_raddr = span_a;
            end
            S_Q_RD2:
            begin
                pre_re    = 1'b1;
                pre_raddr = lo_a;
            end
            S_Q_GO:
            begin
                mul_go  = 1'b1;
                mul_req = '{a_wrap: pre_w, b_wrap: pow_w, a_mod: pre_m, b_mod: pow_m};
            end
            default: ;
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        len_next       = len_reg;
        zstat_next     = zstat_reg;
        rsp_valid_next = 1'b0;
        rsp_next       = rsp_reg;
        if (accept)
        begin
            case (op_in)
                OP_CLEAR:
                begin
                    len_next   = '0;
                    zstat_next = STAT_OK;
                end
                OP_APPEND: zstat_next = STAT_FULL;
                OP_QUERY:  zstat_next = STAT_RANGE;
                default:   zstat_next = STAT_OK;
            endcase
        end
        case (state_reg)
            S_ZERO:
            begin
                rsp_valid_next = 1'b1;
                rsp_next       = '{hash_wrap: '0, hash_mod: '0, status: zstat_reg};
            end
            S_A_WR:
            begin
                len_next       = len_reg + AW'(1);
                rsp_valid_next = 1'b1;
                rsp_next       = '{hash_wrap: hold_w_reg, hash_mod: hold_m_reg,
                                   status: STAT_OK};
            end
            S_Q_OUT:
            begin
                rsp_valid_next = 1'b1;
                rsp_next       = '{hash_wrap: hold_w_reg - prod_w, hash_mod: sub_red,
                                   status: STAT_OK};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            zstat_reg     <= STAT_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            zstat_reg     <= zstat_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (accept)
            cmd_reg <= cmd;
        if (state_reg == S_A_WT1 && mul_done)
        begin
            hold_w_reg <= prod_w + WRAP_W'(cmd_reg.char_code);
            hold_m_reg <= app_red;
        end
        if (state_reg == S_Q_RD2)
        begin
            hold_w_reg <= pre_w;
            hold_m_reg <= pre_m;
        end
    end

    // Prefix table.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            pre_mem[waddr] <= {hold_w_reg, hold_m_reg};
        if (pre_re)
        begin
            pre_rd_reg   <= pre_mem[pre_raddr];
            pre_zero_reg <= (pre_raddr == '0);
        end
    end

    // Power table.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            pow_mem[waddr] <= {prod_w, prod_m};
        if (pow_re)
        begin
            pow_rd_reg   <= pow_mem[pow_raddr];
            pow_zero_reg <= (pow_raddr == '0);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

FILE: rtl/core/drh_checker.sv
// Port checker for the double rolling substring hash block, with its bind.
`default_nettype none
module drh_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire drh_pkg::cmd_t cmd,
    input wire logic          rsp_valid,
    input wire drh_pkg::rsp_t rsp
);
    import drh_pkg::*;

    // An accepted transaction holds the block busy.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy low after accepted transaction");

    // Accepted command carries known bits.
    a_cmd_known: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> !$isunknown(cmd))
        else $error("unknown command accepted");

    // A response closes a busy period and frees the command side.
    a_rsp_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !busy && $past(busy))
        else $error("response outside a busy period");

    // Modular hash always reduced.
    a_mod_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.hash_mod < HASH_MODULUS)
        else $error("hash_mod not reduced");

    // Error statuses carry zero hashes.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == STAT_FULL || rsp.status == STAT_RANGE)
            |-> rsp.hash_wrap == '0 && rsp.hash_mod == '0)
        else $error("error response with nonzero hash");

endmodule

bind double_rolling_substring_hash drh_checker u_drh_checker (.*);
`default_nettype wire
